[rtl/dmtt_pkg.sv]
// Shared types, codes and sizing constants for the delayed message timer table.
package dmtt_pkg;

   // Default number of message slots in the table.
   localparam int DMTT_SLOT_COUNT = 32;

   // Depth of the command queue between the front and the engine.
   localparam int DMTT_QUEUE_DEPTH = 2;

   // Input action codes.
   localparam logic ACTION_SCHEDULE = 1'b0;
   localparam logic ACTION_TICK     = 1'b1;

   // Result kind codes.
   localparam logic [1:0] KIND_SCHEDULED = 2'd0;
   localparam logic [1:0] KIND_REJECTED  = 2'd1;
   localparam logic [1:0] KIND_DELIVERED = 2'd2;

   // One classified command as it waits in the queue.
   typedef struct packed {
      logic        is_tick;
      logic [31:0] delay;
      logic [31:0] target;
      logic [31:0] arg_one;
      logic [31:0] arg_two;
      logic [31:0] arg_three;
   } cmd_type;

   // One entry of the slot memory.
   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] target;
      logic [31:0] word_one;
      logic [31:0] word_two;
      logic [31:0] word_three;
   } slot_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCHED,
      ST_TICK,
      ST_FLUSH
   } engine_state_type;

endpackage

[rtl/delayed_message_timer_table.sv]
// Top level of the delayed message timer table.
//
// This block keeps a 32-bit wrapping frame counter and a table of SLOT_COUNT delayed
// messages. A word with action 0 schedules a message: it is written into the lowest slot
// whose deadline is below the current frame, with deadline frame + delay (mod 2^32), and
// one answer word comes back with kind scheduled, or kind rejected when no slot is free.
// A word with action 1 is a frame tick: the frame advances by one and every slot whose
// deadline equals the new frame is delivered as one word, in slot order, with last set
// on the final one; a tick with nothing due produces no word at all. Delivered slots keep
// their deadline and fire again if the frame comes back around to it. After reset every
// slot reads as deadline zero, so nothing can be scheduled until the first tick.
// Timing: incoming words are taken into a two-entry command queue, so the request side
// keeps moving while the engine works, until the queue is full. The engine handles one
// command at a time and scans the slot memory one slot per cycle through its single read
// port. A schedule scans from slot zero and stops at the first free slot, or at the last
// slot with a reject; a tick scans every slot and then passes a flush state. Each result
// word sits in an output register, and stall on the result side holds the scan only when
// a further word is ready to go out. No clearing pass is needed after reset: per-slot
// valid bits make unwritten slots read as zero.
module delayed_message_timer_table #(
   parameter int SLOT_COUNT = dmtt_pkg::DMTT_SLOT_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_delay,
   input  logic [31:0] req_target,
   input  logic [31:0] req_arg_one,
   input  logic [31:0] req_arg_two,
   input  logic [31:0] req_arg_three,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_out_target,
   output logic [31:0] rsp_out_arg_one,
   output logic [31:0] rsp_out_arg_two,
   output logic [31:0] rsp_out_arg_three,
   output logic        rsp_last
);
   import dmtt_pkg::*;

   // Queue head and pop handshake between the front and the engine.
   logic    q_vld;
   logic    q_pop;
   cmd_type q_cmd;

   // The front takes request words and classifies them as schedule or tick commands.
   dmtt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_delay     (req_delay),
      .req_target    (req_target),
      .req_arg_one   (req_arg_one),
      .req_arg_two   (req_arg_two),
      .req_arg_three (req_arg_three),
      .q_vld         (q_vld),
      .q_pop         (q_pop),
      .q_cmd         (q_cmd)
   );

   // The engine owns the frame counter and slot memory and produces every result word.
   dmtt_engine #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .q_vld             (q_vld),
      .q_pop             (q_pop),
      .q_cmd             (q_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_target    (rsp_out_target),
      .rsp_out_arg_one   (rsp_out_arg_one),
      .rsp_out_arg_two   (rsp_out_arg_two),
      .rsp_out_arg_three (rsp_out_arg_three),
      .rsp_last          (rsp_last)
   );

endmodule

[rtl/dmtt_front.sv]
// Input front end: accepts request words, classifies them and queues them for the engine.
module dmtt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_action,
   input  logic [31:0]      req_delay,
   input  logic [31:0]      req_target,
   input  logic [31:0]      req_arg_one,
   input  logic [31:0]      req_arg_two,
   input  logic [31:0]      req_arg_three,
   output logic             q_vld,
   input  logic             q_pop,
   output dmtt_pkg::cmd_type q_cmd
);
   import dmtt_pkg::*;

   localparam int PTR_W = (DMTT_QUEUE_DEPTH > 1) ? $clog2(DMTT_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(DMTT_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DMTT_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DMTT_QUEUE_DEPTH);

   cmd_type        queue_ff [DMTT_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic           push;
   cmd_type        new_cmd;

   assign req_stall = (count_ff == CNT_FULL);
   assign push      = req_valid && !req_stall;
   assign q_vld     = (count_ff != '0);
   assign q_cmd     = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.is_tick   = (req_action == ACTION_TICK);
      new_cmd.delay     = req_delay;
      new_cmd.target    = req_target;
      new_cmd.arg_one   = req_arg_one;
      new_cmd.arg_two   = req_arg_two;
      new_cmd.arg_three = req_arg_three;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

[rtl/dmtt_engine.sv]
// Back end: frame counter, slot memory, slot scan sequencer and result register.
module dmtt_engine #(
   parameter int SLOT_COUNT = dmtt_pkg::DMTT_SLOT_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_vld,
   output logic             q_pop,
   input  dmtt_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_out_target,
   output logic [31:0]      rsp_out_arg_one,
   output logic [31:0]      rsp_out_arg_two,
   output logic [31:0]      rsp_out_arg_three,
   output logic             rsp_last
);
   import dmtt_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

   engine_state_type state_ff, state_in;

   slot_type          slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] slot_vld_ff;
   slot_type          rd_ff;
   logic              rd_vld_ff;
   slot_type          rd_eff;
   slot_type          wr_slot;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]       frame_ff, frame_in;
   cmd_type           cmd_ff;
   logic [31:0]       deadline_ff;

   slot_type          hold_ff;
   logic              hold_vld_ff;

   logic              out_vld_ff;
   logic [1:0]        out_kind_ff;
   logic [31:0]       out_target_ff;
   logic [31:0]       out_arg_one_ff;
   logic [31:0]       out_arg_two_ff;
   logic [31:0]       out_arg_three_ff;
   logic              out_last_ff;

   logic              out_free;
   logic              at_last;
   logic              hit_less;
   logic              hit_eq;
   logic              tick_step;
   logic              mem_we;
   logic              push;
   logic [1:0]        push_kind;
   logic              push_last;
   slot_type          push_slot;
   logic              hold_ld;
   logic              hold_clr;
   logic              cmd_ld;

   // Slots never written read as the all-zero reset entry.
   assign rd_eff    = rd_vld_ff ? rd_ff : '0;
   assign hit_less  = (rd_eff.deadline < frame_ff);
   assign hit_eq    = (rd_eff.deadline == frame_ff);
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign at_last   = (idx_ff == IDX_LAST);
   assign tick_step = !hit_eq || !hold_vld_ff || out_free;

   always_comb begin
      wr_slot.deadline   = deadline_ff;
      wr_slot.target     = cmd_ff.target;
      wr_slot.word_one   = cmd_ff.arg_one;
      wr_slot.word_two   = cmd_ff.arg_two;
      wr_slot.word_three = cmd_ff.arg_three;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               state_in = q_cmd.is_tick ? ST_TICK : ST_SCHED;
            end
         end
         ST_SCHED: begin
            if ((hit_less || at_last) && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (tick_step && at_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_vld_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls.
   always_comb begin
      q_pop     = 1'b0;
      cmd_ld    = 1'b0;
      idx_in    = idx_ff;
      frame_in  = frame_ff;
      mem_we    = 1'b0;
      push      = 1'b0;
      push_kind = KIND_SCHEDULED;
      push_last = 1'b1;
      push_slot = '0;
      hold_ld   = 1'b0;
      hold_clr  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               q_pop  = 1'b1;
               cmd_ld = 1'b1;
               idx_in = '0;
               if (q_cmd.is_tick) begin
                  frame_in = frame_ff + 32'd1;
               end
            end
         end
         ST_SCHED: begin
            if (hit_less) begin
               if (out_free) begin
                  mem_we = 1'b1;
                  push   = 1'b1;
               end
            end else if (at_last) begin
               if (out_free) begin
                  push      = 1'b1;
                  push_kind = KIND_REJECTED;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_TICK: begin
            if (tick_step) begin
               if (hit_eq) begin
                  hold_ld = 1'b1;
                  if (hold_vld_ff) begin
                     push      = 1'b1;
                     push_kind = KIND_DELIVERED;
                     push_last = 1'b0;
                     push_slot = hold_ff;
                  end
               end
               if (!at_last) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (hold_vld_ff && out_free) begin
               push      = 1'b1;
               push_kind = KIND_DELIVERED;
               push_last = 1'b1;
               push_slot = hold_ff;
               hold_clr  = 1'b1;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         frame_ff    <= '0;
         slot_vld_ff <= '0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         if (mem_we) begin
            slot_vld_ff[idx_ff] <= 1'b1;
         end
         if (hold_ld) begin
            hold_vld_ff <= 1'b1;
         end else if (hold_clr) begin
            hold_vld_ff <= 1'b0;
         end
         if (push) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Slot memory: one write port, one registered read port addressed by the next index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= wr_slot;
      end
      rd_ff     <= slot_mem[idx_in];
      rd_vld_ff <= slot_vld_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd_ld) begin
         cmd_ff      <= q_cmd;
         deadline_ff <= frame_ff + q_cmd.delay;
      end
      if (hold_ld) begin
         hold_ff <= rd_eff;
      end
      if (push) begin
         out_kind_ff      <= push_kind;
         out_target_ff    <= push_slot.target;
         out_arg_one_ff   <= push_slot.word_one;
         out_arg_two_ff   <= push_slot.word_two;
         out_arg_three_ff <= push_slot.word_three;
         out_last_ff      <= push_last;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_out_target    = out_target_ff;
   assign rsp_out_arg_one   = out_arg_one_ff;
   assign rsp_out_arg_two   = out_arg_two_ff;
   assign rsp_out_arg_three = out_arg_three_ff;
   assign rsp_last          = out_last_ff;

`ifndef NO_ASSERTIONS
   // A held delivery exists only while a tick is being scanned or flushed.
   hold_only_in_tick_a: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> (state_ff == ST_TICK || state_ff == ST_FLUSH))
      else $error("held delivery outside a tick");

   // Schedule answers are single, final and carry no message.
   sched_answer_a: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_kind_ff != KIND_DELIVERED) |->
      (out_last_ff && out_target_ff == 32'd0 && out_arg_one_ff == 32'd0))
      else $error("malformed schedule answer");

   // The frame advances by exactly one on a tick and holds otherwise.
   frame_tick_a: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd.is_tick) |=> (frame_ff == $past(frame_ff) + 32'd1))
      else $error("frame did not advance on tick");

   frame_hold_a: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_cmd.is_tick) |=> $stable(frame_ff))
      else $error("frame changed without a tick");

   // A slot is written only together with a scheduled answer.
   write_with_answer_a: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (push && push_kind == KIND_SCHEDULED && state_ff == ST_SCHED))
      else $error("slot write without scheduled answer");
`endif

endmodule
